[rtl/llfc_pkg.sv]
// Shared types and constants for the link loss fallback controller.
// No dependencies; imported by every other file of the block except llfc_res_if.
package llfc_pkg;

    localparam int SEC_W   = 16;               // width of a seconds register
    localparam int MS_PER_S = 1000;
    localparam int MS_W    = 26;               // 65535 * 1000 fits in 26 bits
    localparam int TS_W    = 32;               // millisecond timestamp width
    localparam int IDX_W   = 3;                // config index, room for unused codes

    localparam logic [SEC_W-1:0] TIMEOUT_RST    = SEC_W'(300);
    localparam logic [SEC_W-1:0] CYCLE_ON_RST   = SEC_W'(600);
    localparam logic [SEC_W-1:0] CYCLE_OFF_RST  = SEC_W'(600);
    localparam logic [SEC_W-1:0] LOCAL_LIM_RST  = SEC_W'(3600);

    typedef enum logic [IDX_W-1:0] {
        CFG_TIMEOUT   = 3'd0,
        CFG_CYCLE_ON  = 3'd1,
        CFG_CYCLE_OFF = 3'd2,
        CFG_LOCAL_LIM = 3'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        LVL_NORMAL = 2'd0,
        LVL_LOCAL  = 2'd1,
        LVL_FIXED  = 2'd2
    } level_t;

    typedef enum logic {
        OP_EVALUATE = 1'b0,
        OP_SERVER_MSG = 1'b1
    } opcode_t;

    // Limits already scaled to milliseconds
    typedef struct packed {
        logic [MS_W-1:0] timeout_ms;
        logic [MS_W-1:0] cycle_on_ms;
        logic [MS_W-1:0] cycle_off_ms;
        logic [MS_W-1:0] local_lim_ms;
    } cfg_ms_t;

    typedef struct packed {
        logic            opcode;
        logic [TS_W-1:0] now_ms;
        logic            link_up;
        logic            sensor_present;
    } item_t;

    typedef struct packed {
        logic [1:0] level;
        logic       in_fallback;
        logic       relay_on;
    } result_t;

    function automatic logic [MS_W-1:0] sec_to_ms(input logic [SEC_W-1:0] secs);
        return MS_W'(secs) * MS_W'(MS_PER_S);
    endfunction

endpackage

[rtl/llfc_evt_if.sv]
// Event channel interface: valid/ready plus the event payload.
// Depends on llfc_pkg for the timestamp width.
interface llfc_evt_if
    import llfc_pkg::*;
;
    logic            valid;
    logic            ready;
    logic            opcode;
    logic [TS_W-1:0] now_ms;
    logic            link_up;
    logic            sensor_present;

    modport source (output valid, output opcode, output now_ms, output link_up,
                    output sensor_present, input ready);
    modport sink   (input valid, input opcode, input now_ms, input link_up,
                    input sensor_present, output ready);
endinterface

[rtl/llfc_res_if.sv]
// Result channel interface: valid/ready plus level, fallback flag and relay drive.
// No package dependency.
interface llfc_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] level;
    logic       in_fallback;
    logic       relay_on;

    modport source (output valid, output level, output in_fallback, output relay_on,
                    input ready);
    modport sink   (input valid, input level, input in_fallback, input relay_on,
                    output ready);
endinterface

[rtl/llfc_cfg_regs.sv]
// Configuration registers, stored pre-scaled to milliseconds.
// Depends on llfc_pkg.
module llfc_cfg_regs
    import llfc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [SEC_W-1:0] cfg_wdata,
    output cfg_ms_t          cfg_ms
);

    cfg_ms_t cfg_reg;
    cfg_ms_t cfg_next;
    logic [MS_W-1:0] wdata_ms;

    assign wdata_ms = sec_to_ms(cfg_wdata);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TIMEOUT:   cfg_next.timeout_ms   = wdata_ms;
                CFG_CYCLE_ON:  cfg_next.cycle_on_ms  = wdata_ms;
                CFG_CYCLE_OFF: cfg_next.cycle_off_ms = wdata_ms;
                CFG_LOCAL_LIM: cfg_next.local_lim_ms = wdata_ms;
                default:       cfg_next = cfg_reg;   // unused index: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ms   <= sec_to_ms(TIMEOUT_RST);
            cfg_reg.cycle_on_ms  <= sec_to_ms(CYCLE_ON_RST);
            cfg_reg.cycle_off_ms <= sec_to_ms(CYCLE_OFF_RST);
            cfg_reg.local_lim_ms <= sec_to_ms(LOCAL_LIM_RST);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ms = cfg_reg;

endmodule

[rtl/llfc_core.sv]
// Fallback state and per-event evaluation logic; state commits on step_en.
// Depends on llfc_pkg.
module llfc_core
    import llfc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  item_t   item,
    input  cfg_ms_t cfg_ms,
    output result_t result
);

    logic [TS_W-1:0] last_msg_reg,    last_msg_next;
    logic [TS_W-1:0] cycle_start_reg, cycle_start_next;
    level_t          level_reg,       level_next;
    logic            phase_on_reg,    phase_on_next;

    logic [TS_W-1:0] msg_elapsed;
    logic [TS_W-1:0] cyc_elapsed;
    logic [MS_W-1:0] phase_len;
    logic            timeout_hit;
    logic            local_hit;
    logic            phase_hit;

    assign msg_elapsed = item.now_ms - last_msg_reg;
    assign cyc_elapsed = item.now_ms - cycle_start_reg;
    assign phase_len   = phase_on_reg ? cfg_ms.cycle_on_ms : cfg_ms.cycle_off_ms;
    assign timeout_hit = msg_elapsed >= TS_W'(cfg_ms.timeout_ms);
    assign local_hit   = msg_elapsed >= TS_W'(cfg_ms.local_lim_ms);
    assign phase_hit   = cyc_elapsed >= TS_W'(phase_len);

    always_comb
    begin
        last_msg_next    = last_msg_reg;
        cycle_start_next = cycle_start_reg;
        level_next       = level_reg;
        phase_on_next    = phase_on_reg;
        priority if (item.opcode == OP_SERVER_MSG)
        begin
            last_msg_next = item.now_ms;
        end
        else if (item.link_up)
        begin
            if (level_reg != LVL_NORMAL)
            begin
                level_next    = LVL_NORMAL;
                last_msg_next = item.now_ms;
            end
        end
        else
        begin
            unique case (level_reg)
                LVL_NORMAL:
                begin
                    if (timeout_hit)
                    begin
                        if (item.sensor_present)
                        begin
                            level_next = LVL_LOCAL;
                        end
                        else
                        begin
                            level_next       = LVL_FIXED;
                            cycle_start_next = item.now_ms;
                            phase_on_next    = 1'b1;
                        end
                    end
                end
                LVL_LOCAL:
                begin
                    if (local_hit)
                    begin
                        level_next       = LVL_FIXED;
                        cycle_start_next = item.now_ms;
                        phase_on_next    = 1'b1;
                    end
                end
                default:   // fixed cycle, and the unused code treated likewise
                begin
                    if (phase_hit)
                    begin
                        phase_on_next    = ~phase_on_reg;
                        cycle_start_next = item.now_ms;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        result.level       = level_next;
        result.in_fallback = (level_next != LVL_NORMAL);
        result.relay_on    = (level_next == LVL_FIXED) && phase_on_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_msg_reg    <= '0;
            cycle_start_reg <= '0;
            level_reg       <= LVL_NORMAL;
            phase_on_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            last_msg_reg    <= last_msg_next;
            cycle_start_reg <= cycle_start_next;
            level_reg       <= level_next;
            phase_on_reg    <= phase_on_next;
        end
    end

endmodule

[rtl/link_loss_fallback_controller.sv]
// Top level of the link loss fallback controller: event stage, core, result register.
// Depends on llfc_pkg, llfc_evt_if, llfc_res_if, llfc_cfg_regs and llfc_core.
//
// Usage:
//  - evt (sink) takes one event transaction per cycle while evt.ready is high: opcode (0 evaluate,
//    1 server message), now_ms, link_up and sensor_present.
//  - res (source) returns exactly one result transaction per event, in order:
//    level, in_fallback and relay_on as they stand after that event.
//  - cfg_we/cfg_index/cfg_wdata write the four seconds registers (timeout,
//    on phase, off phase, local limit). Write only while no event is in flight.
//    The value is scaled to milliseconds on the way into the register.
//  - An accepted event passes through the event register and then the result
//    register before it shows up on res.
//  - Throughput: one event per cycle while res is taken; fallback state updates in
//    the cycle the event leaves the event register; the next event sees it at once.
//  - Stall: if res is not taken, the result register holds, the event
//    register holds, and evt.ready drops once both are full. A new event is
//    still taken while a finished result waits, as long as the event stage
//    is free or moving.
//  - Reset: registers return to 300/600/600/3600 s, level normal, both
//    timestamps zero, phase off, and both pipeline stages empty.
module link_loss_fallback_controller
    import llfc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    llfc_evt_if.sink         evt,
    llfc_res_if.source       res,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [SEC_W-1:0] cfg_wdata
);

    cfg_ms_t cfg_ms;

    // event stage
    logic    evt_valid_reg, evt_valid_next;
    item_t   evt_item_reg;
    // result stage
    logic    res_valid_reg, res_valid_next;
    result_t res_data_reg;

    result_t core_result;
    logic    step;      // event stage moves into the result register
    logic    take;      // new event transaction accepted

    llfc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg_ms    (cfg_ms)
    );

    llfc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step),
        .item    (evt_item_reg),
        .cfg_ms  (cfg_ms),
        .result  (core_result)
    );

    assign step      = evt_valid_reg && (!res_valid_reg || res.ready);
    assign evt.ready = !evt_valid_reg || step;
    assign take      = evt.valid && evt.ready;

    always_comb
    begin
        evt_valid_next = take || (evt_valid_reg && !step);
        res_valid_next = step || (res_valid_reg && !res.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            evt_valid_reg <= evt_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            evt_item_reg.opcode         <= evt.opcode;
            evt_item_reg.now_ms         <= evt.now_ms;
            evt_item_reg.link_up        <= evt.link_up;
            evt_item_reg.sensor_present <= evt.sensor_present;
        end
        if (step)
        begin
            res_data_reg <= core_result;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.level       = res_data_reg.level;
    assign res.in_fallback = res_data_reg.in_fallback;
    assign res.relay_on    = res_data_reg.relay_on;

endmodule
